// ----- src/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

   localparam int unsigned PRIO_W    = 8;
   localparam int unsigned DATA_W    = 16;
   localparam int unsigned FILL_W    = 5;
   localparam int unsigned DEF_DEPTH = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic              operation;
      logic [PRIO_W-1:0] priority_req;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PRIO_W-1:0] out_priority;
      logic [DATA_W-1:0] out_payload;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic      ins_en;
      logic      rem_en;
      entry_type new_entry;
   } cmd_type;

endpackage
`default_nettype wire

// ----- src/spq_cell.sv -----
`default_nettype none
module spq_cell #(
   parameter int unsigned CNT_W = 5,
   parameter int unsigned INDEX = 0
) (
   input  wire                  clock,
   input  spq_pkg::cmd_type     cmd,
   input  wire [CNT_W-1:0]      count,
   input  wire                  left_gt,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry,
   output logic                 gt
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      at_end;

   assign occupied = count > CNT_W'(INDEX);
   assign at_end   = count == CNT_W'(INDEX);
   assign gt       = occupied && (entry_ff.prio > cmd.new_entry.prio);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.rem_en) begin
         entry_in = right_entry;
      end else if (cmd.ins_en) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_end) begin
            entry_in = cmd.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ----- src/sorted_priority_queue_top.sv -----
// Sorted priority queue of DEPTH entries held in a row of cells, lowest
// priority value at the head. Each request transfer (insert or remove)
// gives one response transfer, registered and valid in the next cycle; the
// block takes one request per cycle while responses are taken. Inserts go
// behind all entries of equal priority. A full insert is dropped with status
// full, a remove on an empty queue returns status empty. The cell contents
// are not cleared by reset; only the fill count and the response valid are.
`default_nettype none
module sorted_priority_queue_top #(
   parameter int unsigned DEPTH = spq_pkg::DEF_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  spq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output spq_pkg::rsp_type  rsp_data
);
   import spq_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             accept, full, empty;
   cmd_type          cmd;
   entry_type        cell_q [DEPTH];
   logic             cell_gt [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;

   assign cmd.ins_en         = accept && (req_data.operation == OP_INSERT) && !full;
   assign cmd.rem_en         = accept && (req_data.operation == OP_REMOVE) && !empty;
   assign cmd.new_entry.prio = req_data.priority_req;
   assign cmd.new_entry.data = req_data.payload;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell #(
         .CNT_W(CNT_W),
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .left_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
         .left_entry ((i == 0) ? cmd.new_entry : cell_q[(i == 0) ? 0 : i-1]),
         .right_entry((i == DEPTH-1) ? cell_q[i] : cell_q[(i == DEPTH-1) ? i : i+1]),
         .entry      (cell_q[i]),
         .gt         (cell_gt[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.rem_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = ST_OK;
         rsp_data_in.out_priority = '0;
         rsp_data_in.out_payload  = '0;
         rsp_data_in.fill_level   = FILL_W'(count_in);
         if (req_data.operation == OP_INSERT) begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end
         end else if (empty) begin
            rsp_data_in.status = ST_EMPTY;
         end else begin
            rsp_data_in.out_priority = cell_q[0].prio;
            rsp_data_in.out_payload  = cell_q[0].data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.operation == OP_INSERT) && full |=> $stable(count_ff))
      else $error("dropped insert changed fill count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_q[0].prio <= cell_q[1].prio))
      else $error("head entries out of order");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      accept && !(cmd.rem_en) |=>
         (rsp_data_ff.out_priority == '0) && (rsp_data_ff.out_payload == '0))
      else $error("non-remove response carries entry data");
`endif

endmodule
`default_nettype wire
